// ===== src/sva_pkg.sv =====
// Shared types and constants of the synthesizer voice allocator.
`timescale 1ns / 1ps
package sva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_STATUS   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BEND    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_SILENCE = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ON  = 2'd1,
        MODE_REL = 2'd2
    } t_mode;

    // Register index of channel_mono_mask (byte address bit 2).
    localparam logic CFG_IDX_MONO_MASK = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_DISPATCH, S_CLEAR, S_ENTRY, S_REL_FIRST, S_REL_LAST,
        S_BEST, S_BEST_END, S_OFF_CLR, S_OFF_BEND, S_MONO, S_MONO_BEND,
        S_PICK, S_PICK_END, S_STEAL, S_START
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_CAPTURE, DP_ALL_OFF, DP_STATUS, DP_RD_ENTRY, DP_LATCH,
        DP_CLEAR_STEP, DP_RELEASE, DP_BEST_STEP, DP_WR_HELD0, DP_OFF_BEND,
        DP_MONO_STEP, DP_MONO_BEND, DP_PICK_STEP, DP_PICK_SEL, DP_STEAL_STEP,
        DP_START
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   init;
        logic   last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_range;
        logic mono;
        logic held;
        logic nscan_done;
        logic clr_done;
        logic best_found;
        logic mono_hit;
        logic vscan_last;
        logic stolen;
        logic fifo_empty;
    } t_sts;

    typedef struct packed {
        t_act       action;
        logic [3:0] voice;
        logic [6:0] note;
        logic [3:0] channel;
        logic [7:0] patch;
        logic       last;
    } t_result;

endpackage

// ===== src/sva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sva_ctrl.sv =====
// Sequencer of the voice allocator: walks each event through its steps.
`timescale 1ns / 1ps
module sva_ctrl import sva_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_WAIT;
            S_WAIT:     if (i_sts.fifo_empty) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_ALL_OFF: n_state = S_CLEAR;
                    OP_STATUS:  n_state = S_IDLE;
                    default:    n_state = i_sts.in_range ? S_ENTRY : S_IDLE;
                endcase
            end
            S_CLEAR:    if (i_sts.clr_done) n_state = S_IDLE;
            S_ENTRY: begin
                if (i_sts.op == OP_NOTE_OFF) begin
                    if (!i_sts.held)     n_state = S_IDLE;
                    else if (i_sts.mono) n_state = S_BEST;
                    else                 n_state = S_REL_LAST;
                end else begin
                    if (!i_sts.mono && i_sts.held) n_state = S_REL_FIRST;
                    else if (i_sts.mono)           n_state = S_MONO;
                    else                           n_state = S_PICK;
                end
            end
            S_REL_FIRST: n_state = S_PICK;
            S_REL_LAST:  n_state = S_IDLE;
            S_BEST:      if (i_sts.nscan_done) n_state = S_BEST_END;
            S_BEST_END:  n_state = i_sts.best_found ? S_OFF_CLR : S_REL_LAST;
            S_OFF_CLR:   n_state = S_OFF_BEND;
            S_OFF_BEND:  n_state = S_IDLE;
            S_MONO: begin
                if (i_sts.mono_hit)        n_state = S_MONO_BEND;
                else if (i_sts.vscan_last) n_state = S_PICK;
            end
            S_MONO_BEND: n_state = S_IDLE;
            S_PICK:      if (i_sts.vscan_last) n_state = S_PICK_END;
            S_PICK_END:  n_state = i_sts.stolen ? S_STEAL : S_START;
            S_STEAL:     if (i_sts.nscan_done) n_state = S_START;
            S_START:     n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '{op: DP_NOP, init: 1'b0, last: 1'b0};
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = DP_CAPTURE;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_ALL_OFF: o_cmd = '{op: DP_ALL_OFF, init: 1'b1, last: 1'b1};
                    OP_STATUS:  o_cmd.op = DP_STATUS;
                    default:    if (i_sts.in_range) o_cmd.op = DP_RD_ENTRY;
                endcase
            end
            S_CLEAR:     o_cmd.op = DP_CLEAR_STEP;
            S_ENTRY:     o_cmd = '{op: DP_LATCH, init: 1'b1, last: 1'b0};
            S_REL_FIRST: o_cmd = '{op: DP_RELEASE, init: 1'b1, last: 1'b0};
            S_REL_LAST:  o_cmd = '{op: DP_RELEASE, init: 1'b0, last: 1'b1};
            S_BEST:      o_cmd.op = DP_BEST_STEP;
            S_OFF_CLR:   o_cmd.op = DP_WR_HELD0;
            S_OFF_BEND:  o_cmd = '{op: DP_OFF_BEND, init: 1'b0, last: 1'b1};
            S_MONO: begin
                o_cmd.op   = DP_MONO_STEP;
                o_cmd.init = !i_sts.mono_hit && i_sts.vscan_last;
            end
            S_MONO_BEND: o_cmd = '{op: DP_MONO_BEND, init: 1'b0, last: 1'b1};
            S_PICK:      o_cmd.op = DP_PICK_STEP;
            S_PICK_END:  o_cmd = '{op: DP_PICK_SEL, init: 1'b1, last: 1'b0};
            S_STEAL:     o_cmd.op = DP_STEAL_STEP;
            S_START:     o_cmd = '{op: DP_START, init: 1'b0, last: 1'b1};
            default:     o_cmd.op = DP_NOP;
        endcase
    end

`ifndef SYNTHESIS
    a_dispatch_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISPATCH) |-> i_sts.fifo_empty)
        else $error("dispatch with results still queued");
`endif

endmodule

// ===== src/sva_dp.sv =====
// Datapath: note table, voice state, search registers and result queue.
`timescale 1ns / 1ps
module sva_dp import sva_pkg::*; #(
    parameter int VOICES   = 16,
    parameter int CHANNELS = 16,
    parameter int NOTES    = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [7:0]  i_patch,
    input  logic [3:0]  i_voice_index,
    input  logic [15:0] i_volume,
    input  logic        i_finished,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic [15:0] o_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    localparam int DEPTH = CHANNELS * NOTES;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int VW    = VOICES > 1 ? $clog2(VOICES) : 1;
    localparam int NCW   = $clog2(NOTES + 1);
    localparam int EW    = 33 + VW;

    // captured event
    t_op         r_op;
    logic [3:0]  r_ch;
    logic [6:0]  r_note;
    logic [7:0]  r_patch;
    logic [3:0]  r_vi;
    logic [15:0] r_vol;
    logic        r_fin;
    logic [15:0] r_mask;

    logic [31:0] r_age;
    logic [VW-1:0] r_ent_v;
    logic [NCW-1:0] r_ncnt;
    logic [VW-1:0]  r_vcnt;
    logic [AW-1:0]  r_ccnt;

    logic          r_best_found;
    logic [6:0]    r_best_m;
    logic [31:0]   r_best_age;
    logic [VW-1:0] r_best_v;

    logic          r_free_found, r_rel_found, r_nt_found;
    logic [VW-1:0] r_free_v, r_rel_v, r_nt_v, r_min_v;
    logic [15:0]   r_rel_lvl, r_min_lvl;
    logic [VW-1:0] r_sel;
    logic [3:0]    r_old_ch;

    t_mode       r_vmode [VOICES];
    logic [6:0]  r_vnote [VOICES];
    logic [3:0]  r_vch   [VOICES];
    logic [15:0] r_vlvl  [VOICES];

    t_result    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_qn;

    logic          we;
    logic [AW-1:0] waddr, raddr, idx_i, proc_addr, scan_base;
    logic [EW-1:0] wdata, rdata;
    logic          rd_held;
    logic [VW-1:0] rd_v;
    logic [31:0]   rd_age;
    logic [3:0]    ch_scan;
    logic [6:0]    m_proc;
    logic          proc_valid, nscan_done, stat_ok;
    logic [VW-1:0] v_ra, chosen;
    t_mode         rv_mode;
    logic [6:0]    rv_note;
    logic [3:0]    rv_ch;
    logic [15:0]   rv_lvl;
    logic          mono_hit, push, pop, age_step;
    t_result       res;

    sva_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_held = rdata[EW-1];
    assign rd_v    = rdata[32 +: VW];
    assign rd_age  = rdata[31:0];

    assign idx_i      = AW'(32'(r_ch) * NOTES + 32'(r_note));
    assign ch_scan    = (i_cmd.op == DP_STEAL_STEP) ? r_old_ch : r_ch;
    assign scan_base  = AW'(32'(ch_scan) * NOTES);
    assign proc_addr  = AW'(32'(ch_scan) * NOTES + 32'(r_ncnt) - 32'd1);
    assign m_proc     = 7'(32'(r_ncnt) - 32'd1);
    assign proc_valid = r_ncnt != '0;
    assign nscan_done = r_ncnt == NCW'(NOTES);
    assign stat_ok    = 32'(r_vi) < VOICES;

    // note table read address: the event's entry, or the scan pointer
    always_comb begin
        raddr = idx_i;
        if (i_cmd.op == DP_BEST_STEP || i_cmd.op == DP_STEAL_STEP) begin
            raddr = nscan_done ? scan_base : AW'(32'(scan_base) + 32'(r_ncnt));
        end
    end

    // note table write port
    always_comb begin
        we    = 1'b0;
        waddr = idx_i;
        wdata = '0;
        case (i_cmd.op)
            DP_CLEAR_STEP: begin
                we    = 1'b1;
                waddr = r_ccnt;
            end
            DP_RELEASE, DP_WR_HELD0: we = 1'b1;
            DP_OFF_BEND: begin
                we    = 1'b1;
                waddr = AW'(32'(r_ch) * NOTES + 32'(r_best_m));
                wdata = {1'b1, r_best_v, r_age};
            end
            DP_MONO_BEND, DP_START: begin
                we    = 1'b1;
                wdata = {1'b1, r_sel, r_age};
            end
            DP_STEAL_STEP: begin
                we    = proc_valid && rd_held && (rd_v == r_sel);
                waddr = proc_addr;
                wdata = {1'b0, rd_v, rd_age};
            end
            default: we = 1'b0;
        endcase
    end

    // single voice read address per cycle
    always_comb begin
        case (i_cmd.op)
            DP_RELEASE:                  v_ra = r_ent_v;
            DP_MONO_STEP, DP_PICK_STEP:  v_ra = r_vcnt;
            DP_PICK_SEL:                 v_ra = chosen;
            DP_STATUS:                   v_ra = VW'(r_vi);
            default:                     v_ra = r_sel;
        endcase
    end

    assign rv_mode  = r_vmode[v_ra];
    assign rv_note  = r_vnote[v_ra];
    assign rv_ch    = r_vch[v_ra];
    assign rv_lvl   = r_vlvl[v_ra];
    assign mono_hit = (rv_mode == MODE_ON) && (rv_ch == r_ch);

    // allocation order: free, quietest releasing, same note, quietest
    assign chosen = r_free_found ? r_free_v :
                    r_rel_found  ? r_rel_v  :
                    r_nt_found   ? r_nt_v   : r_min_v;

    assign age_step = (i_cmd.op == DP_OFF_BEND) || (i_cmd.op == DP_MONO_BEND) ||
                      (i_cmd.op == DP_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_age  <= '0;
            r_ccnt <= '0;
            r_ncnt <= '0;
            r_vcnt <= '0;
        end else begin
            if (i_cfg_we) r_mask <= i_cfg_wdata;
            if (age_step) r_age <= r_age + 32'd1;
            if (i_cmd.init) begin
                r_ccnt <= '0;
                r_ncnt <= '0;
                r_vcnt <= '0;
            end else begin
                case (i_cmd.op)
                    DP_CLEAR_STEP: r_ccnt <= r_ccnt + 1'b1;
                    DP_BEST_STEP, DP_STEAL_STEP: begin
                        if (!nscan_done) r_ncnt <= r_ncnt + 1'b1;
                    end
                    DP_MONO_STEP, DP_PICK_STEP: r_vcnt <= r_vcnt + 1'b1;
                    default: r_vcnt <= r_vcnt;
                endcase
            end
        end
    end

    // event capture and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CAPTURE) begin
            r_op    <= t_op'(i_operation);
            r_ch    <= i_channel;
            r_note  <= i_note;
            r_patch <= i_patch;
            r_vi    <= i_voice_index;
            r_vol   <= i_volume;
            r_fin   <= i_finished;
        end
        if (i_cmd.op == DP_LATCH) r_ent_v <= rd_v;
        if (i_cmd.init) begin
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
            r_rel_found  <= 1'b0;
            r_nt_found   <= 1'b0;
        end
        case (i_cmd.op)
            DP_BEST_STEP: begin
                if (proc_valid && rd_held && (m_proc != r_note) &&
                    (!r_best_found || rd_age > r_best_age)) begin
                    r_best_found <= 1'b1;
                    r_best_m     <= m_proc;
                    r_best_age   <= rd_age;
                    r_best_v     <= rd_v;
                end
            end
            DP_MONO_STEP: if (mono_hit) r_sel <= r_vcnt;
            DP_PICK_STEP: begin
                if (rv_mode == MODE_OFF && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_v     <= r_vcnt;
                end
                if (rv_mode == MODE_REL && (!r_rel_found || rv_lvl < r_rel_lvl)) begin
                    r_rel_found <= 1'b1;
                    r_rel_v     <= r_vcnt;
                    r_rel_lvl   <= rv_lvl;
                end
                if (rv_note == r_note) begin
                    r_nt_found <= 1'b1;
                    r_nt_v     <= r_vcnt;
                end
                if (r_vcnt == '0 || rv_lvl < r_min_lvl) begin
                    r_min_v   <= r_vcnt;
                    r_min_lvl <= rv_lvl;
                end
            end
            DP_PICK_SEL: begin
                r_sel    <= chosen;
                r_old_ch <= rv_ch;
            end
            default: r_sel <= r_sel;
        endcase
    end

    // voice state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_vmode[v] <= MODE_OFF;
                r_vlvl[v]  <= '0;
            end
        end else begin
            case (i_cmd.op)
                DP_ALL_OFF: begin
                    for (int v = 0; v < VOICES; v++) r_vmode[v] <= MODE_OFF;
                end
                DP_STATUS: begin
                    if (stat_ok) begin
                        r_vlvl[v_ra] <= r_vol;
                        if (r_fin && rv_mode == MODE_REL) r_vmode[v_ra] <= MODE_OFF;
                    end
                end
                DP_RELEASE: if (rv_mode != MODE_OFF) r_vmode[v_ra] <= MODE_REL;
                DP_START:   r_vmode[r_sel] <= MODE_ON;
                default:    r_vmode[r_sel] <= r_vmode[r_sel];
            endcase
        end
    end

    // voice note and channel
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_OFF_BEND:  r_vnote[r_best_v] <= r_best_m;
            DP_MONO_BEND: r_vnote[r_sel] <= r_note;
            DP_START: begin
                r_vnote[r_sel] <= r_note;
                r_vch[r_sel]   <= r_ch;
            end
            default: r_vch[r_sel] <= r_vch[r_sel];
        endcase
    end

    // result formation
    always_comb begin
        push = 1'b1;
        res  = '{action: ACT_SILENCE, voice: 4'd0, note: 7'd0, channel: 4'd0,
                 patch: 8'd0, last: i_cmd.last};
        case (i_cmd.op)
            DP_ALL_OFF: res.action = ACT_SILENCE;
            DP_RELEASE: begin
                res.action  = ACT_RELEASE;
                res.voice   = 4'(r_ent_v);
                res.note    = r_note;
                res.channel = r_ch;
            end
            DP_OFF_BEND: begin
                res.action  = ACT_BEND;
                res.voice   = 4'(r_best_v);
                res.note    = r_best_m;
                res.channel = r_ch;
            end
            DP_MONO_BEND: begin
                res.action  = ACT_BEND;
                res.voice   = 4'(r_sel);
                res.note    = r_note;
                res.channel = r_ch;
            end
            DP_START: begin
                res.action  = ACT_START;
                res.voice   = 4'(r_sel);
                res.note    = r_note;
                res.channel = r_ch;
                res.patch   = r_patch;
            end
            default: push = 1'b0;
        endcase
    end

    assign o_valid  = r_qn != 2'd0;
    assign o_result = r_q[r_rp];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_qn <= r_qn + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= res;
    end

    assign o_mask = r_mask;

    assign o_sts = '{
        op:         r_op,
        in_range:   (32'(r_ch) < CHANNELS) && (32'(r_note) < NOTES),
        mono:       r_mask[r_ch],
        held:       rd_held,
        nscan_done: nscan_done,
        clr_done:   r_ccnt == AW'(DEPTH - 1),
        best_found: r_best_found,
        mono_hit:   mono_hit,
        vscan_last: r_vcnt == VW'(VOICES - 1),
        stolen:     rv_mode != MODE_OFF,
        fifo_empty: r_qn == 2'd0
    };

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qn == 2'd2) |-> !push)
        else $error("result pushed into full queue");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule

// ===== src/synth_voice_allocator.sv =====
// Polyphonic voice allocator: top level with handshake and register port.
// Per event: an all-off queues its result at dispatch, then clears the note table; a
// release reads the entry; a start scans the voices (after a release on a re-press and
// after the mono scan on a mono miss), then the old channel's notes when stealing; a
// mono bend ends the voice scan on a hit; a mono note-off scans the channel's notes. One
// event at a time; the next, taken in idle, waits while earlier results sit downstream.
`timescale 1ns / 1ps
module synth_voice_allocator import sva_pkg::*; #(
    parameter int VOICES   = 16,
    parameter int CHANNELS = 16,
    parameter int NOTES    = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [7:0]  i_patch,
    input  logic [3:0]  i_voice_index,
    input  logic [15:0] i_volume,
    input  logic        i_finished,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_action,
    output logic [3:0]  o_voice,
    output logic [6:0]  o_out_note,
    output logic [3:0]  o_out_channel,
    output logic [7:0]  o_out_patch,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Reset: synchronous active low; a clearing pass over the note table follows reset
    // and every all-off event, during which no event is taken (register writes
    // still are).

    t_cmd        cmd;
    t_sts        sts;
    t_result     result;
    logic [15:0] mask;
    logic        cfg_we;

    // A transaction on the register port completes in the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MONO_MASK);
    assign prdata = (paddr[2] == CFG_IDX_MONO_MASK) ? {16'd0, mask} : 32'd0;

    // Sequencer: holds the event in flight, one datapath step per cycle unless results wait.
    sva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Datapath: note table RAM, voice registers, search state, two-entry
    // result queue that lets a new event in while results wait downstream.
    sva_dp #(
        .VOICES   (VOICES),
        .CHANNELS (CHANNELS),
        .NOTES    (NOTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_channel     (i_channel),
        .i_note        (i_note),
        .i_patch       (i_patch),
        .i_voice_index (i_voice_index),
        .i_volume      (i_volume),
        .i_finished    (i_finished),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (pwdata[15:0]),
        .o_mask        (mask),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (result)
    );

    assign o_action      = result.action;
    assign o_voice       = result.voice;
    assign o_out_note    = result.note;
    assign o_out_channel = result.channel;
    assign o_out_patch   = result.patch;
    assign o_last        = result.last;

endmodule

// ===== test/tb_synth_voice_allocator.sv =====
// Self-checking testbench of the synthesizer voice allocator.
`timescale 1ns / 1ps
module tb_synth_voice_allocator import sva_pkg::*; ();

    localparam int NV = 16;
    localparam int NC = 16;
    localparam int NN = 128;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        t_op         op;
        logic [3:0]  ch;
        logic [6:0]  note;
        logic [7:0]  patch;
        logic [3:0]  vidx;
        logic [15:0] vol;
        logic        fin;
    } t_event;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [1:0]  i_operation;
    logic [3:0]  i_channel;
    logic [6:0]  i_note;
    logic [7:0]  i_patch;
    logic [3:0]  i_voice_index;
    logic [15:0] i_volume;
    logic        i_finished;
    logic        o_valid, i_ready;
    logic [1:0]  o_action;
    logic [3:0]  o_voice;
    logic [6:0]  o_out_note;
    logic [3:0]  o_out_channel;
    logic [7:0]  o_out_patch;
    logic        o_last;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    synth_voice_allocator i_dut (.*);

    // Stimulus and scoreboard storage.
    t_event  pending_events[$];
    t_result expected_actions[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      event_taken = 0;
    bit      hold_off_req = 0;
    int      hold_off_left = 0;

    // Shadow allocator state.
    logic [15:0] mono_mask;
    logic        held_tab[NC*NN];
    logic [3:0]  voice_tab[NC*NN];
    logic [31:0] age_tab[NC*NN];
    logic [31:0] age_ctr;
    t_mode       vmode[NV];
    logic [6:0]  vnote[NV];
    logic [3:0]  vchan[NV];
    logic [15:0] vlevel[NV];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycles, what);
        mismatches++;
    endtask

    task automatic push_action(input t_act a, input int v, input int n, input int c,
                               input int p, input logic lst);
        t_result r;
        r.action  = a;
        r.voice   = v[3:0];
        r.note    = n[6:0];
        r.channel = c[3:0];
        r.patch   = p[7:0];
        r.last    = lst;
        expected_actions.push_back(r);
    endtask

    task automatic release_held(input int c, input int n, input logic lst);
        int v;
        v = voice_tab[c*NN+n];
        held_tab[c*NN+n] = 0;
        if (vmode[v] != MODE_OFF) vmode[v] = MODE_REL;
        push_action(ACT_RELEASE, v, n, c, 0, lst);
    endtask

    function automatic int choose_voice(input int n);
        int best;
        best = NV;
        for (int i = 0; i < NV; i++)
            if (vmode[i] == MODE_OFF) return i;
        for (int i = 0; i < NV; i++)
            if (vmode[i] == MODE_REL && (best == NV || vlevel[i] < vlevel[best])) best = i;
        if (best < NV) return best;
        for (int i = 0; i < NV; i++)
            if (vnote[i] == n) best = i;
        if (best < NV) return best;
        best = 0;
        for (int i = 1; i < NV; i++)
            if (vlevel[i] < vlevel[best]) best = i;
        return best;
    endfunction

    // Work out the actions one accepted event causes.
    task automatic predict_actions(input t_event e);
        int c, n, idx, v, best;
        bit mono;
        c = e.ch;
        n = e.note;
        idx = c*NN + n;
        mono = mono_mask[c];
        case (e.op)
            OP_ALL_OFF: begin
                for (int i = 0; i < NV; i++) vmode[i] = MODE_OFF;
                for (int i = 0; i < NC*NN; i++) held_tab[i] = 0;
                push_action(ACT_SILENCE, 0, 0, 0, 0, 1'b1);
            end
            OP_STATUS: begin
                vlevel[e.vidx] = e.vol;
                if (e.fin && vmode[e.vidx] == MODE_REL) vmode[e.vidx] = MODE_OFF;
            end
            OP_NOTE_OFF: begin
                if (held_tab[idx]) begin
                    best = NN;
                    if (mono)
                        for (int m = 0; m < NN; m++)
                            if (m != n && held_tab[c*NN+m] &&
                                (best == NN || age_tab[c*NN+m] > age_tab[c*NN+best]))
                                best = m;
                    if (best < NN) begin
                        // Fall back to the newest other held note of the channel.
                        held_tab[idx] = 0;
                        age_tab[c*NN+best] = age_ctr;
                        age_ctr++;
                        v = voice_tab[c*NN+best];
                        vnote[v] = best[6:0];
                        push_action(ACT_BEND, v, best, c, 0, 1'b1);
                    end else begin
                        release_held(c, n, 1'b1);
                    end
                end
            end
            default: begin
                if (!mono && held_tab[idx]) release_held(c, n, 1'b0);
                v = NV;
                if (mono)
                    for (int i = 0; i < NV; i++)
                        if (v == NV && vmode[i] == MODE_ON && vchan[i] == c) v = i;
                if (v < NV) begin
                    held_tab[idx] = 1;
                    voice_tab[idx] = v[3:0];
                    age_tab[idx] = age_ctr;
                    age_ctr++;
                    vnote[v] = e.note;
                    push_action(ACT_BEND, v, n, c, 0, 1'b1);
                end else begin
                    v = choose_voice(n);
                    if (vmode[v] != MODE_OFF)
                        for (int m = 0; m < NN; m++)
                            if (held_tab[vchan[v]*NN+m] && voice_tab[vchan[v]*NN+m] == v)
                                held_tab[vchan[v]*NN+m] = 0;
                    held_tab[idx] = 1;
                    voice_tab[idx] = v[3:0];
                    age_tab[idx] = age_ctr;
                    age_ctr++;
                    vmode[v] = MODE_ON;
                    vnote[v] = e.note;
                    vchan[v] = e.ch;
                    push_action(ACT_START, v, n, c, e.patch, 1'b1);
                end
            end
        endcase
    endtask

    // Monitor: check actions against the oldest expectation, then predict new events.
    always @(posedge i_clk) begin
        t_result x;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_actions.size() == 0) begin
                    report_mismatch("action with no event waiting on it");
                end else begin
                    x = expected_actions.pop_front();
                    if (o_action !== x.action)
                        report_mismatch($sformatf("action %0d, want %0d", o_action, x.action));
                    if (o_voice !== x.voice)
                        report_mismatch($sformatf("voice %0d, want %0d", o_voice, x.voice));
                    if (o_out_note !== x.note)
                        report_mismatch($sformatf("note %0d, want %0d", o_out_note, x.note));
                    if (o_out_channel !== x.channel)
                        report_mismatch($sformatf("channel %0d, want %0d",
                                                  o_out_channel, x.channel));
                    if (o_out_patch !== x.patch)
                        report_mismatch($sformatf("patch %0d, want %0d", o_out_patch, x.patch));
                    if (o_last !== x.last)
                        report_mismatch($sformatf("last %0d, want %0d", o_last, x.last));
                end
            end
            if (i_valid && o_ready) begin
                t_event e;
                e.op = t_op'(i_operation);
                e.ch = i_channel;
                e.note = i_note;
                e.patch = i_patch;
                e.vidx = i_voice_index;
                e.vol = i_volume;
                e.fin = i_finished;
                predict_actions(e);
                event_taken = 1;
            end
        end
    end

    // Driver: hold the transaction until taken, then advance or idle.
    always @(negedge i_clk) begin
        t_event e;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || event_taken) begin
            event_taken = 0;
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                e = pending_events.pop_front();
                i_valid       <= 1;
                i_operation   <= e.op;
                i_channel     <= e.ch;
                i_note        <= e.note;
                i_patch       <= e.patch;
                i_voice_index <= e.vidx;
                i_volume      <= e.vol;
                i_finished    <= e.fin;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 0;
            hold_off_left = 400;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_event(input t_op op, input int c, input int n, input int p,
                             input int vi, input int vol, input int fin);
        t_event e;
        e.op = op;
        e.ch = c[3:0];
        e.note = n[6:0];
        e.patch = p[7:0];
        e.vidx = vi[3:0];
        e.vol = vol[15:0];
        e.fin = fin[0];
        pending_events.push_back(e);
    endtask

    task automatic write_mono_mask(input logic [15:0] value);
        @(negedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {CFG_IDX_MONO_MASK, 2'b00};
        pwdata <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        mono_mask = value;
    endtask

    // Wait until every pending event is sent and every expected action has come, then let the block settle.
    task automatic wait_drained();
        while (pending_events.size() > 0 || i_valid || expected_actions.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random events: mostly note traffic on a few channels and a small note pool,
    // so that held notes, mono fallbacks and stealing come up often.
    task automatic add_random_events(input int count);
        int r, c, n;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            c = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
            n = ($urandom_range(9) == 0) ? $urandom_range(127) : 60 + $urandom_range(11);
            if (r < 48)
                add_event(OP_NOTE_ON, c, n, $urandom_range(255), $urandom, $urandom, $urandom);
            else if (r < 80)
                add_event(OP_NOTE_OFF, c, n, $urandom, $urandom, $urandom, $urandom);
            else if (r < 98)
                add_event(OP_STATUS, $urandom, $urandom, $urandom, $urandom_range(15),
                          $urandom_range(65535), $urandom_range(3) != 0);
            else
                add_event(OP_ALL_OFF, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
        end
    endtask

    initial begin
        logic [15:0] masks[4];
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_operation = OP_NOTE_ON;
        i_channel = 0;
        i_note = 0;
        i_patch = 0;
        i_voice_index = 0;
        i_volume = 0;
        i_finished = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        mono_mask = 0;
        age_ctr = 0;
        for (int i = 0; i < NC*NN; i++) held_tab[i] = 0;
        for (int i = 0; i < NV; i++) begin
            vmode[i] = MODE_OFF;
            vnote[i] = 0;
            vchan[i] = 0;
            vlevel[i] = 0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, re-press of a held note, stray note off,
        // status extremes, stealing once all voices sound, and all off.
        write_mono_mask(16'h0000);
        add_event(OP_NOTE_ON, 0, 0, 0, 0, 0, 0);
        add_event(OP_NOTE_ON, 15, 127, 255, 15, 65535, 1);
        add_event(OP_NOTE_ON, 15, 127, 17, 0, 0, 0);
        add_event(OP_NOTE_OFF, 15, 127, 0, 0, 0, 0);
        add_event(OP_NOTE_OFF, 15, 127, 0, 0, 0, 0);
        add_event(OP_STATUS, 0, 0, 0, 15, 65535, 1);
        add_event(OP_STATUS, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 16; k++) add_event(OP_NOTE_ON, 1, 40 + k, k, 0, 0, 0);
        add_event(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0);
        add_event(OP_ALL_OFF, 0, 0, 0, 0, 0, 0);
        wait_drained();

        masks[0] = 16'hFFFF;
        masks[1] = 16'h0000;
        masks[2] = 16'h5555;
        masks[3] = $urandom_range(65535);
        for (int ph = 0; ph < 4; ph++) begin
            write_mono_mask(masks[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            add_random_events(345);
            if (ph == 0) begin
                // Hold the receiver off while events keep coming.
                @(posedge i_clk);
                hold_off_req = 1;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sva_pkg.sv
src/sva_ram.sv
src/sva_ctrl.sv
src/sva_dp.sv
src/synth_voice_allocator.sv
test/tb_synth_voice_allocator.sv
